FILE: sv/rxr_pkg.sv
`default_nettype none

package rxr_pkg;

    localparam int RXR_DEPTH_DEFAULT = 256;
    localparam int BYTE_W            = 8;
    localparam int OP_W              = 3;
    localparam int S_DATA_W          = 32;
    localparam int M_DATA_W          = 32;

    typedef enum logic [OP_W-1:0] {
        OP_RECEIVE      = 3'd0,
        OP_PEEK         = 3'd1,
        OP_CONSUME      = 3'd2,
        OP_CLEAR        = 3'd3,
        OP_LINE_ERROR   = 3'd4,
        OP_TAKE_OVERRUN = 3'd5
    } rxr_op_t;

endpackage

`default_nettype wire

FILE: sv/rxr_ring_mem.sv
`default_nettype none

module rxr_ring_mem #(
    parameter int RING_DEPTH = rxr_pkg::RXR_DEPTH_DEFAULT,
    parameter int IDX_W      = $clog2(RING_DEPTH)
) (
    input  wire logic                       clk,
    input  wire logic                       wr_en,
    input  wire logic [IDX_W-1:0]           wr_addr,
    input  wire logic [rxr_pkg::BYTE_W-1:0] wr_data,
    input  wire logic                       rd_en,
    input  wire logic [IDX_W-1:0]           rd_addr,
    output logic      [rxr_pkg::BYTE_W-1:0] rd_data
);
    import rxr_pkg::*;

    logic [BYTE_W-1:0] mem [RING_DEPTH];
    logic [BYTE_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

FILE: sv/rx_circular_ring_tracker.sv
// Receive ring tracker.
// Input stream (s_*): one beat per operation - receive a byte, peek at an
// offset from the oldest unread byte, consume a count, clear, line error,
// or take the sticky overrun flag. Every beat gives exactly one result beat
// on the output stream (m_*) with the peeked byte, hit flag, unread count,
// bytes consumed and the overrun flag.
// A beat accepted at an edge shows its result in the next cycle. Throughput
// is one beat per cycle while the result register is empty or drained; the
// pointer update and peek address settle between the accept and the result
// register, and the byte store is one write plus one registered read port.
// s_tready stays high while the result register is empty or being drained,
// so an accepted result never waits on the input side. When the receiver
// stalls (m_tready low with m_tvalid high) the result holds and s_tready
// drops until it is taken.
// Reset clears both pointers, the unread count, the overrun flag and the
// output valid; the byte store is not cleared, and only bytes written since
// reset can ever be peeked.
// Unread is reported in its low eight bits; at most RING_DEPTH-1 bytes are
// ever unread, a receive that would fill the ring drops all unread bytes.

`default_nettype none

module rx_circular_ring_tracker #(
    parameter int RING_DEPTH = rxr_pkg::RXR_DEPTH_DEFAULT
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        s_tvalid,
    output logic                             s_tready,
    // operation[2:0], rx_byte[10:3], offset[18:11], count[26:19], zero fill
    input  wire logic [rxr_pkg::S_DATA_W-1:0] s_tdata,
    output logic                             m_tvalid,
    input  wire logic                        m_tready,
    // peek_data[7:0], peek_hit[8], unread[16:9], consumed[24:17],
    // overrun[25], zero fill
    output logic      [rxr_pkg::M_DATA_W-1:0] m_tdata
);
    import rxr_pkg::*;

    localparam int IDX_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int CMP_W = ((IDX_W > BYTE_W) ? IDX_W : BYTE_W) + 1;
    localparam logic [CMP_W-1:0] DEPTH_C = CMP_W'(RING_DEPTH);

    // pointers kept as indices, unread tracked separately
    logic [IDX_W-1:0] wr_idx_reg, wr_idx_next;
    logic [IDX_W-1:0] rd_idx_reg, rd_idx_next;
    logic [IDX_W-1:0] unread_reg, unread_next;
    logic             overrun_reg, overrun_next;

    logic              m_tvalid_reg;
    logic              peek_hit_reg;
    logic [BYTE_W-1:0] unread_out_reg;
    logic [BYTE_W-1:0] consumed_reg;
    logic              overrun_out_reg;

    logic              accept;
    rxr_op_t           op;
    logic [BYTE_W-1:0] rx_byte;
    logic [BYTE_W-1:0] offset;
    logic [BYTE_W-1:0] count;

    logic [CMP_W-1:0]  unread_ext;
    logic [CMP_W-1:0]  used;
    logic [CMP_W-1:0]  peek_sum;
    logic [CMP_W-1:0]  peek_addr;
    logic [CMP_W-1:0]  rd_sum;
    logic [CMP_W-1:0]  rd_wrapped;
    logic [CMP_W-1:0]  unread_after;
    logic              peek_hit;
    logic              flag_out;
    logic              mem_wr;
    logic              mem_rd;
    logic [BYTE_W-1:0] mem_rd_data;

    assign accept  = s_tvalid && s_tready;
    assign op      = rxr_op_t'(s_tdata[OP_W-1:0]);
    assign rx_byte = s_tdata[OP_W +: BYTE_W];
    assign offset  = s_tdata[OP_W+BYTE_W +: BYTE_W];
    assign count   = s_tdata[OP_W+2*BYTE_W +: BYTE_W];

    assign unread_ext = CMP_W'(unread_reg);
    assign peek_hit   = (op == OP_PEEK) && (CMP_W'(offset) < unread_ext);

    // offset < unread < depth, so one wrap is enough
    assign peek_sum  = CMP_W'(rd_idx_reg) + CMP_W'(offset);
    assign peek_addr = (peek_sum >= DEPTH_C) ? (peek_sum - DEPTH_C) : peek_sum;

    assign used = (CMP_W'(count) < unread_ext) ? CMP_W'(count) : unread_ext;

    assign rd_sum     = CMP_W'(rd_idx_reg) + used;
    assign rd_wrapped = (rd_sum >= DEPTH_C) ? (rd_sum - DEPTH_C) : rd_sum;

    always_comb
    begin
        wr_idx_next  = wr_idx_reg;
        rd_idx_next  = rd_idx_reg;
        unread_next  = unread_reg;
        overrun_next = overrun_reg;
        flag_out     = overrun_reg;
        unique case (op)
            OP_RECEIVE:
            begin
                if (CMP_W'(wr_idx_reg) == DEPTH_C - CMP_W'(1))
                    wr_idx_next = '0;
                else
                    wr_idx_next = wr_idx_reg + IDX_W'(1);
                if (unread_ext == DEPTH_C - CMP_W'(1))
                begin
                    // ring lapped: drop everything unread
                    rd_idx_next  = wr_idx_next;
                    unread_next  = '0;
                    overrun_next = 1'b1;
                end
                else
                begin
                    unread_next = unread_reg + IDX_W'(1);
                end
                flag_out = overrun_next;
            end
            OP_CONSUME:
            begin
                rd_idx_next = rd_wrapped[IDX_W-1:0];
                unread_next = unread_reg - used[IDX_W-1:0];
            end
            OP_CLEAR:
            begin
                rd_idx_next = wr_idx_reg;
                unread_next = '0;
            end
            OP_LINE_ERROR:
            begin
                wr_idx_next  = '0;
                rd_idx_next  = '0;
                unread_next  = '0;
                overrun_next = 1'b1;
                flag_out     = 1'b1;
            end
            OP_TAKE_OVERRUN:
            begin
                overrun_next = 1'b0;
            end
            default:
            begin
            end
        endcase
    end

    assign unread_after = CMP_W'(unread_next);
    assign mem_wr       = accept && (op == OP_RECEIVE);
    assign mem_rd       = accept && peek_hit;

    rxr_ring_mem #(
        .RING_DEPTH (RING_DEPTH),
        .IDX_W      (IDX_W)
    ) u_ring_mem (
        .clk     (clk),
        .wr_en   (mem_wr),
        .wr_addr (wr_idx_reg),
        .wr_data (rx_byte),
        .rd_en   (mem_rd),
        .rd_addr (peek_addr[IDX_W-1:0]),
        .rd_data (mem_rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_idx_reg   <= '0;
            rd_idx_reg   <= '0;
            unread_reg   <= '0;
            overrun_reg  <= 1'b0;
            m_tvalid_reg <= 1'b0;
            peek_hit_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                wr_idx_reg   <= wr_idx_next;
                rd_idx_reg   <= rd_idx_next;
                unread_reg   <= unread_next;
                overrun_reg  <= overrun_next;
                m_tvalid_reg <= 1'b1;
                peek_hit_reg <= peek_hit;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            unread_out_reg  <= unread_after[BYTE_W-1:0];
            consumed_reg    <= (op == OP_CONSUME) ? used[BYTE_W-1:0] : '0;
            overrun_out_reg <= flag_out;
        end
    end

    assign s_tready = !m_tvalid_reg || m_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {6'b0, overrun_out_reg, consumed_reg, unread_out_reg,
                       peek_hit_reg, peek_hit_reg ? mem_rd_data : '0};

endmodule

`default_nettype wire

FILE: sv/rxr_checker.sv
`default_nettype none

module rxr_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [31:0] m_tdata
);

    // stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    // every accepted beat gives a result on the next cycle
    a_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> m_tvalid)
        else $error("accepted beat produced no result");

    // empty result register never blocks the input
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input blocked with empty result register");

    // a peek miss reports a zero byte
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[8] |-> m_tdata[7:0] == 8'd0)
        else $error("peek miss with nonzero data");

    // a peek never consumes
    a_hit_no_consume: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[8] |-> m_tdata[24:17] == 8'd0)
        else $error("peek hit with nonzero consumed count");

endmodule

bind rx_circular_ring_tracker rxr_checker u_rxr_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

FILE: tb/sv/tb_top.sv
`default_nettype none

localparam int RING_SLOTS = rxr_pkg::RXR_DEPTH_DEFAULT;

typedef struct packed {
    logic [7:0] peek_data;
    logic       peek_hit;
    logic [7:0] unread;
    logic [7:0] consumed;
    logic       overrun;
} ring_status_t;

class ring_scoreboard;
    logic [7:0]   ring_mem [RING_SLOTS];
    int unsigned  wr_cnt;
    int unsigned  rd_cnt;
    bit           ovr_flag;
    ring_status_t status_q [$];
    int           mismatches;
    int           results_seen;
    int           laps;
    int           peek_hits;
    int           peek_misses;
    int           clipped;

    function new();
        foreach (ring_mem[i])
            ring_mem[i] = '0;
        wr_cnt       = 0;
        rd_cnt       = 0;
        ovr_flag     = 1'b0;
        mismatches   = 0;
        results_seen = 0;
        laps         = 0;
        peek_hits    = 0;
        peek_misses  = 0;
        clipped      = 0;
    endfunction

    function int unsigned unread();
        return (wr_cnt + 2 * RING_SLOTS - rd_cnt) % (2 * RING_SLOTS);
    endfunction

    function int pending();
        return status_q.size();
    endfunction

    // producer has caught the consumer: drop everything unread
    function void drop_if_lapped();
        if (unread() >= RING_SLOTS)
        begin
            rd_cnt   = wr_cnt;
            ovr_flag = 1'b1;
            laps++;
        end
    endfunction

    function void note_op(input logic [rxr_pkg::S_DATA_W-1:0] d);
        logic [2:0]   op;
        logic [7:0]   rx_byte;
        logic [7:0]   offset;
        logic [7:0]   count;
        int unsigned  avail;
        ring_status_t s;
        op      = d[2:0];
        rx_byte = d[10:3];
        offset  = d[18:11];
        count   = d[26:19];
        s       = '0;
        drop_if_lapped();
        case (op)
            rxr_pkg::OP_RECEIVE:
            begin
                ring_mem[wr_cnt % RING_SLOTS] = rx_byte;
                wr_cnt = (wr_cnt + 1) % (2 * RING_SLOTS);
                drop_if_lapped();
            end
            rxr_pkg::OP_PEEK:
            begin
                avail = unread();
                if (offset < avail)
                begin
                    s.peek_hit  = 1'b1;
                    s.peek_data = ring_mem[(rd_cnt + offset) % RING_SLOTS];
                    peek_hits++;
                end
                else
                    peek_misses++;
            end
            rxr_pkg::OP_CONSUME:
            begin
                avail = unread();
                s.consumed = (count < avail) ? count : 8'(avail);
                if (count > avail)
                    clipped++;
                rd_cnt = (rd_cnt + s.consumed) % (2 * RING_SLOTS);
            end
            rxr_pkg::OP_CLEAR:
                rd_cnt = wr_cnt;
            rxr_pkg::OP_LINE_ERROR:
            begin
                wr_cnt   = 0;
                rd_cnt   = 0;
                ovr_flag = 1'b1;
            end
            default:
                ;
        endcase
        // take reports the flag as it stood, then clears it
        s.overrun = ovr_flag;
        if (op == rxr_pkg::OP_TAKE_OVERRUN)
            ovr_flag = 1'b0;
        s.unread = 8'(unread());
        status_q.push_back(s);
    endfunction

    function void check_status(input logic [rxr_pkg::M_DATA_W-1:0] d);
        ring_status_t got;
        ring_status_t want;
        got.peek_data = d[7:0];
        got.peek_hit  = d[8];
        got.unread    = d[16:9];
        got.consumed  = d[24:17];
        got.overrun   = d[25];
        results_seen++;
        if (status_q.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("result beat %0d: none expected, got data %02h hit %0b unread %0d",
                         results_seen, got.peek_data, got.peek_hit, got.unread);
            return;
        end
        want = status_q.pop_front();
        if (got.peek_data !== want.peek_data || got.peek_hit !== want.peek_hit ||
            got.unread !== want.unread || got.consumed !== want.consumed ||
            got.overrun !== want.overrun)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display({"result beat %0d (exp/got): data %02h/%02h hit %0b/%0b ",
                          "unread %0d/%0d consumed %0d/%0d overrun %0b/%0b"},
                         results_seen, want.peek_data, got.peek_data,
                         want.peek_hit, got.peek_hit, want.unread, got.unread,
                         want.consumed, got.consumed, want.overrun, got.overrun);
        end
    endfunction
endclass

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int         CYCLE_LIMIT   = 200000;
    localparam int         RANDOM_ITEMS  = 950;
    localparam int         HOLD_AT       = 300;
    localparam int         HOLD_CYCLES   = 48;
    localparam int         PAUSE_AT      = 650;
    localparam int         CALM_FIRST    = 420;
    localparam int         CALM_LAST     = 560;
    localparam int         SETTLE_CYCLES = 4;
    localparam logic [2:0] OP_SPARE_LO   = 3'd6;
    localparam logic [2:0] OP_SPARE_HI   = 3'd7;

    logic                         clk = 1'b0;
    logic                         rst_n = 1'b0;
    logic                         s_tvalid;
    logic                         s_tready;
    logic [rxr_pkg::S_DATA_W-1:0] s_tdata;
    logic                         m_tvalid;
    logic                         m_tready;
    logic [rxr_pkg::M_DATA_W-1:0] m_tdata;

    ring_scoreboard sb;
    int             sent;
    int             directed;
    int             cycles;
    int             holds_done;
    bit             calm;
    bit             hold_req;
    bit             paused;

    rx_circular_ring_tracker u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // results first, so a stray beat never meets an expectation queued at the same edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
                sb.check_status(m_tdata);
            if (s_tvalid && s_tready)
                sb.note_op(s_tdata);
        end
    end

    initial
    begin
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES - 1)
                    @(negedge clk);
                hold_req = 1'b0;
                holds_done++;
            end
            else
                m_tready <= calm || ($urandom_range(99) >= 31);
        end
    end

    function automatic logic [7:0] rnd8();
        return 8'($urandom);
    endfunction

    // called at a falling edge, returns at the falling edge after the beat is taken
    task automatic send_beat(input logic [2:0] op, input logic [7:0] rx_byte,
                             input logic [7:0] offset, input logic [7:0] count);
        while (!calm && $urandom_range(99) < 31)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(rxr_pkg::S_DATA_W - 27){1'b0}}, count, offset, rx_byte, op};
        do
            @(posedge clk);
        while (!s_tready);
        sent++;
        calm = (sent >= CALM_FIRST && sent < CALM_LAST);
        if (sent == HOLD_AT)
            hold_req = 1'b1;
        @(negedge clk);
    endtask

    task automatic fill_ring(input int n);
        repeat (n)
            send_beat(rxr_pkg::OP_RECEIVE, rnd8(), rnd8(), rnd8());
    endtask

    task automatic random_traffic(input int budget);
        int          first;
        int          r;
        int unsigned u;
        logic [7:0]  offset;
        logic [7:0]  count;
        first = sent;
        // open by filling right up to the lapping point, sometimes past it
        fill_ring(RING_SLOTS - 1 - sb.unread() + $urandom_range(0, 2));
        while (sent - first < budget)
        begin
            if (!paused && sent >= PAUSE_AT)
            begin
                s_tvalid <= 1'b0;
                do
                    @(negedge clk);
                while (sb.pending() != 0);
                paused = 1'b1;
            end
            u = sb.unread();
            r = $urandom_range(99);
            if (r < 34)
                fill_ring($urandom_range(1, 24));
            else if (r < 54)
            begin
                repeat ($urandom_range(1, 6))
                begin
                    u = sb.unread();
                    case ($urandom_range(4))
                        0:       offset = rnd8();
                        1:       offset = 8'(u);
                        default: offset = (u == 0) ? rnd8() : 8'($urandom_range(u - 1));
                    endcase
                    send_beat(rxr_pkg::OP_PEEK, rnd8(), offset, rnd8());
                end
            end
            else if (r < 68)
            begin
                count = ($urandom_range(2) == 0) ? rnd8() : 8'($urandom_range(u));
                send_beat(rxr_pkg::OP_CONSUME, rnd8(), rnd8(), count);
            end
            else if (r < 74)
                send_beat(rxr_pkg::OP_CLEAR, rnd8(), rnd8(), rnd8());
            else if (r < 79)
                send_beat(rxr_pkg::OP_LINE_ERROR, rnd8(), rnd8(), rnd8());
            else if (r < 87)
                send_beat(rxr_pkg::OP_TAKE_OVERRUN, rnd8(), rnd8(), rnd8());
            else if (r < 91)
                send_beat($urandom_range(1) ? OP_SPARE_HI : OP_SPARE_LO,
                          rnd8(), rnd8(), rnd8());
            else if (r < 93)
                fill_ring(RING_SLOTS - 1 - u + $urandom_range(0, 2));
            else
                send_beat(3'($urandom), rnd8(), rnd8(), rnd8());
        end
    endtask

    initial
    begin
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        calm       = 1'b0;
        hold_req   = 1'b0;
        paused     = 1'b0;
        sent       = 0;
        cycles     = 0;
        holds_done = 0;
        sb = new();
        repeat (2)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // empty ring: miss, consume of nothing, clear flag, unused codes; then all ops
        send_beat(rxr_pkg::OP_PEEK, 8'h00, 8'h00, 8'h00);
        send_beat(rxr_pkg::OP_CONSUME, 8'h00, 8'h00, 8'hFF);
        send_beat(rxr_pkg::OP_TAKE_OVERRUN, 8'hFF, 8'hFF, 8'hFF);
        send_beat(OP_SPARE_LO, 8'hFF, 8'hFF, 8'hFF);
        send_beat(OP_SPARE_HI, 8'h00, 8'h00, 8'h00);
        send_beat(rxr_pkg::OP_RECEIVE, 8'h00, 8'hFF, 8'hFF);
        send_beat(rxr_pkg::OP_RECEIVE, 8'hFF, 8'h00, 8'h00);
        send_beat(rxr_pkg::OP_RECEIVE, 8'hA5, 8'h00, 8'h00);
        send_beat(rxr_pkg::OP_PEEK, 8'h00, 8'h00, 8'h00);
        send_beat(rxr_pkg::OP_PEEK, 8'h00, 8'h02, 8'h00);
        send_beat(rxr_pkg::OP_PEEK, 8'h00, 8'h03, 8'h00);
        send_beat(rxr_pkg::OP_PEEK, 8'hFF, 8'hFF, 8'hFF);
        send_beat(rxr_pkg::OP_CONSUME, 8'h00, 8'h00, 8'h00);
        send_beat(rxr_pkg::OP_CONSUME, 8'h00, 8'h00, 8'h01);
        send_beat(rxr_pkg::OP_CONSUME, 8'h00, 8'h00, 8'hFF);
        send_beat(rxr_pkg::OP_RECEIVE, 8'h5A, 8'h00, 8'h00);
        send_beat(rxr_pkg::OP_CLEAR, 8'hFF, 8'hFF, 8'hFF);
        send_beat(rxr_pkg::OP_PEEK, 8'h00, 8'h00, 8'h00);
        send_beat(rxr_pkg::OP_LINE_ERROR, 8'h00, 8'h00, 8'h00);
        send_beat(rxr_pkg::OP_TAKE_OVERRUN, 8'h00, 8'h00, 8'h00);
        send_beat(rxr_pkg::OP_TAKE_OVERRUN, 8'h00, 8'h00, 8'h00);
        send_beat(rxr_pkg::OP_RECEIVE, 8'h3C, 8'h00, 8'h00);
        send_beat(rxr_pkg::OP_LINE_ERROR, 8'hFF, 8'hFF, 8'hFF);
        send_beat(rxr_pkg::OP_PEEK, 8'h00, 8'h00, 8'h00);
        send_beat(rxr_pkg::OP_TAKE_OVERRUN, 8'h00, 8'h00, 8'h00);
        directed = sent;

        random_traffic(RANDOM_ITEMS);
        s_tvalid <= 1'b0;

        while (sb.pending() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES)
            @(negedge clk);

        $display("Sent %0d beats (%0d directed), checked %0d results, %0d mismatches.",
                 sent, directed, sb.results_seen, sb.mismatches);
        $display({"Laps %0d, peek hits %0d / misses %0d, clipped consumes %0d, ",
                  "output hold-offs %0d, drain pauses %0d."},
                 sb.laps, sb.peek_hits, sb.peek_misses, sb.clipped, holds_done, paused);
        if (sb.mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

`default_nettype wire
